// ----- sv/mmsd_pkg.sv -----
// mmsd_pkg: shared types and constants for the multiword mod-by-small-divisor block
// used by mmsd_ctrl, mmsd_dp and multiword_mod_small_divisor; no dependencies

package mmsd_pkg;

    localparam int LIMB_WIDTH  = 32;
    localparam int SHIFT_WIDTH = 5;
    localparam int INDEX_WIDTH = 2;

    // configuration register indexes
    localparam logic [INDEX_WIDTH-1:0] REG_DIVISOR    = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_RECIPROCAL = 2'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_SHIFT      = 2'd2;

    // reset values of the configuration registers
    localparam logic [LIMB_WIDTH-1:0]  DIVISOR_RESET    = {1'b1, {(LIMB_WIDTH-1){1'b0}}};
    localparam logic [LIMB_WIDTH-1:0]  RECIPROCAL_RESET = {LIMB_WIDTH{1'b1}};
    localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET      = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ADD,
        ST_MUL2,
        ST_CORR
    } mmsd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // take a new limb beat
        logic mul1;     // remainder times reciprocal
        logic add;      // quotient estimate
        logic mul2;     // estimate times divisor
        logic finish;   // corrections, remainder update
    } mmsd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;     // current limb ends the number
    } mmsd_sts_t;

endpackage

// ----- sv/mmsd_ctrl.sv -----
// mmsd_ctrl: sequencer for the four steps of one limb and the result valid flag
// depends on mmsd_pkg

module mmsd_ctrl
    import mmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mmsd_sts_t  sts,
    output mmsd_cmd_t  cmd
);

    mmsd_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        can_finish;
    logic        accept;

    // a last limb may only finish once the output register is free
    assign can_finish = (state_reg == ST_CORR)
                        && (!sts.last || !out_valid_reg || out_ready);
    assign in_ready   = (state_reg == ST_IDLE) || can_finish;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MUL1;
            end
            ST_MUL1: state_next = ST_ADD;
            ST_ADD:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_CORR;
            ST_CORR:
            begin
                if (accept)
                    state_next = ST_MUL1;
                else if (can_finish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.finish = can_finish;
        case (state_reg)
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_ADD:  cmd.add  = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (can_finish && sts.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL1)
        else $error("accepted limb did not start the multiply step");

    a_hold_on_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORR) && sts.last && out_valid_reg && !out_ready
        |=> (state_reg == ST_CORR) && out_valid_reg)
        else $error("last limb finished over an untaken result");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        can_finish && sts.last |=> out_valid_reg)
        else $error("no result after last limb");

endmodule

// ----- sv/mmsd_dp.sv -----
// mmsd_dp: limb reduction datapath, configuration registers and result register
// depends on mmsd_pkg

module mmsd_dp
    import mmsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mmsd_cmd_t              cmd,
    output mmsd_sts_t              sts,
    input  logic [LIMB_WIDTH-1:0]  limb,
    input  logic                   last,
    input  logic                   wr_en,
    input  logic [INDEX_WIDTH-1:0] wr_index,
    input  logic [LIMB_WIDTH-1:0]  wr_data,
    output logic [LIMB_WIDTH-1:0]  remainder
);

    logic [LIMB_WIDTH-1:0]   div_reg;
    logic [LIMB_WIDTH-1:0]   recip_reg;
    logic [SHIFT_WIDTH-1:0]  shift_reg;
    logic [LIMB_WIDTH-1:0]   rem_reg, rem_next;
    logic [LIMB_WIDTH-1:0]   u_reg;
    logic                    last_reg;
    logic [2*LIMB_WIDTH-1:0] prod_reg;
    logic [LIMB_WIDTH-1:0]   x_reg;
    logic [LIMB_WIDTH-1:0]   q_reg;
    logic [LIMB_WIDTH-1:0]   t_reg;
    logic [LIMB_WIDTH-1:0]   out_reg;

    logic [LIMB_WIDTH:0]     lo_sum;
    logic [LIMB_WIDTH-1:0]   q_next;
    logic [LIMB_WIDTH-1:0]   qd_lo;
    logic [LIMB_WIDTH-1:0]   t_add;
    logic [LIMB_WIDTH-1:0]   t_fix;

    assign sts.last  = last_reg;
    assign remainder = out_reg;

    // x and quotient estimate: (r + 1):u added to the product
    assign lo_sum = {1'b0, prod_reg[LIMB_WIDTH-1:0]} + {1'b0, u_reg};
    assign q_next = prod_reg[2*LIMB_WIDTH-1:LIMB_WIDTH] + rem_reg
                    + {{(LIMB_WIDTH-1){1'b0}}, 1'b1}
                    + {{(LIMB_WIDTH-1){1'b0}}, lo_sum[LIMB_WIDTH]};

    // only the low limb of q * d is needed
    assign qd_lo = q_reg * div_reg;

    // the two corrections
    assign t_add    = (t_reg > x_reg) ? t_reg + div_reg : t_reg;
    assign t_fix    = (t_add >= div_reg) ? t_add - div_reg : t_add;
    assign rem_next = last_reg ? '0 : t_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg   <= DIVISOR_RESET;
            recip_reg <= RECIPROCAL_RESET;
            shift_reg <= SHIFT_RESET;
            rem_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_DIVISOR:    div_reg   <= wr_data;
                    REG_RECIPROCAL: recip_reg <= wr_data;
                    REG_SHIFT:      shift_reg <= wr_data[SHIFT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish)
                rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_reg    <= limb;
            last_reg <= last;
        end
        if (cmd.mul1)
            prod_reg <= {{LIMB_WIDTH{1'b0}}, rem_reg} * {{LIMB_WIDTH{1'b0}}, recip_reg};
        if (cmd.add)
        begin
            x_reg <= lo_sum[LIMB_WIDTH-1:0];
            q_reg <= q_next;
        end
        if (cmd.mul2)
            t_reg <= u_reg - qd_lo;
        if (cmd.finish && last_reg)
            out_reg <= t_fix >> shift_reg;
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && last_reg |=> rem_reg == '0)
        else $error("running remainder not cleared after last limb");

endmodule

// ----- sv/multiword_mod_small_divisor.sv -----
// multiword_mod_small_divisor: top level, remainder of a long number by a small divisor
// depends on mmsd_pkg, mmsd_ctrl, mmsd_dp
//
//  channel  | signals                               | beat taken when
//  ---------+---------------------------------------+---------------------------
//  limb in  | in_valid, in_ready, limb, last        | in_valid & in_ready
//  result   | out_valid, out_ready, remainder       | out_valid & out_ready
//  config   | wr_en, wr_index, wr_data              | wr_en (no handshake)
//
// each limb takes four steps: two dependent multiplies on the previous running
// remainder (remainder times reciprocal, then estimate times divisor) plus an
// add step and a correction step, run by one sequencer over a shared datapath
// the next limb is taken in the cycle its predecessor finishes, so limbs stream
// back to back; a result appears in the cycle after its last limb finishes
// a last limb waits in the correction step while the previous result is untaken
// reset restores divisor 2^31, reciprocal all ones, shift 0 and zero remainder

module multiword_mod_small_divisor
    import mmsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [LIMB_WIDTH-1:0]  limb,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LIMB_WIDTH-1:0]  remainder,
    input  logic                   wr_en,
    input  logic [INDEX_WIDTH-1:0] wr_index,
    input  logic [LIMB_WIDTH-1:0]  wr_data
);

    // command and status between sequencer and datapath
    mmsd_cmd_t cmd;
    mmsd_sts_t sts;

    // sequencer: steps each limb through multiply, add, multiply, correct
    mmsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: config registers, running remainder, stage registers, result
    mmsd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .limb      (limb),
        .last      (last),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .remainder (remainder)
    );

endmodule
